@@ hdl/dr3d_pkg.sv @@
// Shared types and constants for the disparity-to-3D reprojection unit.
package dr3d_pkg;

	localparam int COORD_W   = 24;
	localparam int DIV_STEPS = 24;
	localparam int NUM_W     = 21;
	localparam int DEN_W     = 48;
	localparam int REM_W     = NUM_W + 32;
	localparam int CMP_W     = DEN_W + DIV_STEPS;
	localparam int LANES     = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	localparam logic [COORD_W-1:0] BIG_Z   = 24'd10000;
	localparam logic [COORD_W:0]   POS_LIM = 25'd8388607;
	localparam logic [COORD_W:0]   NEG_LIM = 25'd8388608;
	localparam logic [COORD_W-1:0] OUT_MAX = 24'h7FFFFF;
	localparam logic [COORD_W-1:0] OUT_MIN = 24'h800000;

	localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_W_SCALE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_W_OFFSET    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MISSING     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MISSING_EN  = 3'd6;

	typedef struct packed {
		logic [10:0]        column;
		logic [10:0]        row;
		logic signed [15:0] disparity;
		logic [7:0]         line_label;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
		logic signed [23:0] point_z;
		logic               point_valid;
		logic               overflow;
		logic [7:0]         out_label;
	} out_item_t;

	// per-item flags that ride along the pipeline
	typedef struct packed {
		logic [7:0] label;
		logic       dzero;
		logic       wzero;
		logic       miss;
	} meta_t;

endpackage

@@ hdl/dr3d_in_if.sv @@
// Input channel: one disparity pixel per beat.
interface dr3d_in_if;
	logic                valid;
	logic                ready;
	dr3d_pkg::in_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/dr3d_out_if.sv @@
// Output channel: one 3D point per beat.
interface dr3d_out_if;
	logic                valid;
	logic                ready;
	dr3d_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/disparity_to_3d_reprojection_unit.sv @@
// Disparity-to-3D reprojection unit: streaming Q-matrix reprojection pipeline.
// One pixel beat is taken per cycle while the output side does not stall, and
// one point beat comes out for each, in order. The pipe is dominated by
// the three restoring dividers (X, Y, Z lanes) that retire one
// quotient bit per stage over 24 stages; around them sit a multiply stage, a
// divisor/magnitude stage, a range-check stage, a rounding stage and the
// output register. The whole pipe advances together whenever the output
// register is empty or being taken, so in.ready follows out.ready in the same
// cycle. Divisor W = w_scale*d + 16*w_offset (2^-36 units); each coordinate
// is num*2^32/W, rounded half to even and clamped to 24 bits signed.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only change while no beat is in flight.
module disparity_to_3d_reprojection_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dr3d_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dr3d_pkg::CFG_DAT_W-1:0]      cfg_data,
	dr3d_in_if.sink                             pixel,
	dr3d_out_if.source                          point
);

	localparam int L = dr3d_pkg::LANES;
	localparam int S = dr3d_pkg::DIV_STEPS;

	// ---------------- configuration registers ----------------
	logic signed [16:0] xoff_q, yoff_q;
	logic signed [20:0] focal_q;
	logic signed [31:0] wscale_q, woff_q;
	logic signed [15:0] miss_q;
	logic               missen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xoff_q   <= '0;
			yoff_q   <= '0;
			focal_q  <= '0;
			wscale_q <= '0;
			woff_q   <= '0;
			miss_q   <= '0;
			missen_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				dr3d_pkg::REG_X_OFFSET:   xoff_q   <= cfg_data[16:0];
				dr3d_pkg::REG_Y_OFFSET:   yoff_q   <= cfg_data[16:0];
				dr3d_pkg::REG_FOCAL:      focal_q  <= cfg_data[20:0];
				dr3d_pkg::REG_W_SCALE:    wscale_q <= cfg_data;
				dr3d_pkg::REG_W_OFFSET:   woff_q   <= cfg_data;
				dr3d_pkg::REG_MISSING:    miss_q   <= cfg_data[15:0];
				dr3d_pkg::REG_MISSING_EN: missen_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// whole pipe moves when the output register can take a beat
	logic adv;
	assign adv         = !point.valid || point.ready;
	assign pixel.ready = adv;

	// ---------------- stage 1: W product, numerators ----------------
	logic                     v_s1;
	dr3d_pkg::meta_t          meta_s1;
	logic signed [47:0]       prod_s1;
	logic signed [21:0]       num_s1 [L];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= pixel.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1       <= wscale_q * pixel.data.disparity;
			num_s1[0]     <= $signed({7'd0, pixel.data.column, 4'd0}) + 22'(xoff_q);
			num_s1[1]     <= $signed({7'd0, pixel.data.row, 4'd0}) + 22'(yoff_q);
			num_s1[2]     <= 22'(focal_q);
			meta_s1.label <= pixel.data.line_label;
			meta_s1.dzero <= (pixel.data.disparity == 16'sd0);
			meta_s1.wzero <= 1'b0;
			meta_s1.miss  <= missen_q && (pixel.data.disparity == miss_q);
		end
	end

	// ---------------- stage 2: W, magnitudes, signs ----------------
	logic signed [48:0] wf_c;
	assign wf_c = {prod_s1[47], prod_s1} + {{13{woff_q[31]}}, woff_q, 4'd0};

	logic                                v_s2;
	dr3d_pkg::meta_t                     meta_s2;
	logic [dr3d_pkg::DEN_W-1:0]          den_s2;
	logic [dr3d_pkg::NUM_W-1:0]          nabs_s2 [L];
	logic [L-1:0]                        neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2.label <= meta_s1.label;
			meta_s2.dzero <= meta_s1.dzero;
			meta_s2.miss  <= meta_s1.miss;
			meta_s2.wzero <= (wf_c == 49'sd0);
			den_s2        <= wf_c[48] ? 48'(-wf_c) : wf_c[47:0];
			for (int l = 0; l < L; l++) begin
				nabs_s2[l] <= num_s1[l][21] ? 21'(-num_s1[l]) : num_s1[l][20:0];
				neg_s2[l]  <= num_s1[l][21] ^ wf_c[48];
			end
		end
	end

	// ---------------- stage 3: quotient range check ----------------
	// quotient >= 2^24 saturates outright; otherwise 24 bits cover it
	logic                                v_s3;
	dr3d_pkg::meta_t                     meta_s3;
	logic [dr3d_pkg::DEN_W-1:0]          den_s3;
	logic [dr3d_pkg::REM_W-1:0]          n_s3 [L];
	logic [L-1:0]                        neg_s3, big_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s3 <= meta_s2;
			den_s3  <= den_s2;
			neg_s3  <= neg_s2;
			for (int l = 0; l < L; l++) begin
				n_s3[l]   <= {nabs_s2[l], 32'd0};
				big_s3[l] <= dr3d_pkg::CMP_W'({nabs_s2[l], 32'd0}) >=
				             {den_s2, 24'd0};
			end
		end
	end

	// ---------------- divider: one quotient bit per stage ----------------
	// index k holds the state before step k; bit S-1-k is retired in step k
	logic [S:0]                          v_sd;
	dr3d_pkg::meta_t                     meta_sd  [S+1];
	logic [dr3d_pkg::DEN_W-1:0]          den_sd   [S+1];
	logic [L-1:0]                        neg_sd   [S+1];
	logic [L-1:0]                        big_sd   [S+1];
	logic [dr3d_pkg::REM_W-1:0]          rem_sd   [S+1][L];
	logic [S-1:0]                        q_sd     [S+1][L];

	logic [dr3d_pkg::REM_W-1:0]          rem_nx   [S][L];
	logic [S-1:0]                        q_nx     [S][L];

	always_comb begin
		logic [dr3d_pkg::CMP_W-1:0] sub;
		logic [dr3d_pkg::CMP_W-1:0] rw;
		for (int k = 0; k < S; k++) begin
			for (int l = 0; l < L; l++) begin
				sub = dr3d_pkg::CMP_W'(den_sd[k]) << (S - 1 - k);
				rw  = dr3d_pkg::CMP_W'(rem_sd[k][l]);
				q_nx[k][l] = q_sd[k][l];
				if (rw >= sub) begin
					rem_nx[k][l]            = dr3d_pkg::REM_W'(rw - sub);
					q_nx[k][l][S - 1 - k]   = 1'b1;
				end else begin
					rem_nx[k][l] = rem_sd[k][l];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sd <= '0;
		else if (adv) v_sd <= {v_sd[S-1:0], v_s3};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_sd[0] <= meta_s3;
			den_sd[0]  <= den_s3;
			neg_sd[0]  <= neg_s3;
			big_sd[0]  <= big_s3;
			for (int l = 0; l < L; l++) begin
				rem_sd[0][l] <= n_s3[l];
				q_sd[0][l]   <= '0;
			end
			for (int k = 0; k < S; k++) begin
				meta_sd[k+1] <= meta_sd[k];
				den_sd[k+1]  <= den_sd[k];
				neg_sd[k+1]  <= neg_sd[k];
				big_sd[k+1]  <= big_sd[k];
				for (int l = 0; l < L; l++) begin
					rem_sd[k+1][l] <= rem_nx[k][l];
					q_sd[k+1][l]   <= q_nx[k][l];
				end
			end
		end
	end

	// ---------------- rounding stage: half to even ----------------
	logic                         v_sr;
	dr3d_pkg::meta_t              meta_sr;
	logic [L-1:0]                 neg_sr, big_sr;
	logic [dr3d_pkg::COORD_W:0]   q_sr [L];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sr <= 1'b0;
		else if (adv) v_sr <= v_sd[S];
	end

	always_ff @(posedge clk) begin
		logic [dr3d_pkg::DEN_W:0] twice;
		logic                     up;
		if (adv) begin
			meta_sr <= meta_sd[S];
			neg_sr  <= neg_sd[S];
			big_sr  <= big_sd[S];
			for (int l = 0; l < L; l++) begin
				twice   = {rem_sd[S][l][dr3d_pkg::DEN_W-1:0], 1'b0};
				up      = (twice > {1'b0, den_sd[S]}) ||
				          ((twice == {1'b0, den_sd[S]}) && q_sd[S][l][0]);
				q_sr[l] <= {1'b0, q_sd[S][l]} + {{S{1'b0}}, up};
			end
		end
	end

	// ---------------- output register: clamp and assemble ----------------
	logic [dr3d_pkg::COORD_W-1:0] coord_c [L];
	logic [L-1:0]                 sat_c;

	always_comb begin
		for (int l = 0; l < L; l++) begin
			if (neg_sr[l]) begin
				sat_c[l]   = big_sr[l] || (q_sr[l] > dr3d_pkg::NEG_LIM);
				coord_c[l] = sat_c[l] ? dr3d_pkg::OUT_MIN :
				             dr3d_pkg::COORD_W'(-q_sr[l]);
			end else begin
				sat_c[l]   = big_sr[l] || (q_sr[l] > dr3d_pkg::POS_LIM);
				coord_c[l] = sat_c[l] ? dr3d_pkg::OUT_MAX :
				             q_sr[l][dr3d_pkg::COORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) point.valid <= 1'b0;
		else if (adv) point.valid <= v_sr;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			point.data.out_label <= meta_sr.label;
			if (meta_sr.dzero || meta_sr.wzero) begin
				point.data.point_x     <= '0;
				point.data.point_y     <= '0;
				point.data.point_z     <= '0;
				point.data.point_valid <= 1'b0;
				point.data.overflow    <= !meta_sr.dzero;
			end else begin
				point.data.point_x     <= coord_c[0];
				point.data.point_y     <= coord_c[1];
				point.data.point_z     <= meta_sr.miss ? dr3d_pkg::BIG_Z : coord_c[2];
				point.data.point_valid <= 1'b1;
				point.data.overflow    <= sat_c[0] || sat_c[1] ||
				                          (sat_c[2] && !meta_sr.miss);
			end
		end
	end

`ifndef SYNTHESIS
	// an invalid point always carries zero coordinates
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid && !point.data.point_valid |->
		point.data.point_x == '0 && point.data.point_y == '0 &&
		point.data.point_z == '0)
		else $error("invalid point with nonzero coordinates");

	// a valid point flagged overflow has some coordinate at a clamp bound
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid && point.data.point_valid && point.data.overflow |->
		point.data.point_x == dr3d_pkg::OUT_MAX || point.data.point_x == dr3d_pkg::OUT_MIN ||
		point.data.point_y == dr3d_pkg::OUT_MAX || point.data.point_y == dr3d_pkg::OUT_MIN ||
		point.data.point_z == dr3d_pkg::OUT_MAX || point.data.point_z == dr3d_pkg::OUT_MIN)
		else $error("overflow without a clamped coordinate");

	// a stalled output freezes the input side
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid && !point.ready |-> !pixel.ready)
		else $error("input taken while output stalled");

	// an accepted pixel has entered the first stage in the next cycle
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.ready |=> v_s1)
		else $error("accepted beat lost at pipeline entry");
`endif

endmodule
